// ===== sv/acm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes for the adaptive category model encoder.
package acm_pkg;

	localparam int NumContexts = 8;
	localparam int NumSymbols  = 33;
	localparam int NumEntries  = NumContexts * NumSymbols;

	localparam int CtxReqW  = 3;
	localparam int CtxW     = $clog2(NumContexts);
	localparam int SymW     = $clog2(NumSymbols);
	localparam int AddrW    = $clog2(NumEntries);
	localparam int ResW     = 32;
	localparam int FreqW    = 16;
	localparam int FreqSumW = FreqW + 1;
	localparam int TotalW   = 17;
	localparam int TotSumW  = TotalW + 1;
	localparam int AccW     = 21;
	localparam int MantW    = 31;
	localparam int MbitsW   = 5;
	localparam int CatW     = 6;
	localparam int IncW     = 8;
	localparam int CfgDataW = 17;
	localparam int CfgIdxW  = 1;

	localparam logic [FreqW-1:0]    FreqMax     = {FreqW{1'b1}};
	localparam logic [FreqW-1:0]    FreqInit    = FreqW'(1);
	localparam logic [TotalW-1:0]   TotalMax    = {TotalW{1'b1}};
	localparam logic [TotalW-1:0]   TotalInit   = TotalW'(NumSymbols);
	localparam logic [IncW-1:0]     IncReset    = IncW'(32);
	localparam logic [CfgDataW-1:0] LimitReset  = CfgDataW'(65536);
	localparam logic [SymW-1:0]     LastSym     = SymW'(NumSymbols - 1);

	typedef enum logic [CfgIdxW-1:0] {
		REG_COUNT_INCREMENT,
		REG_TOTAL_LIMIT
	} cfg_reg_t;

	typedef enum logic {
		CMD_CODE,
		CMD_RESET
	} cmd_t;

	typedef enum logic [1:0] {
		WSEL_FILL,
		WSEL_UPDATE,
		WSEL_HALVE
	} wsel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_SCAN,
		ST_UPDATE,
		ST_HALVE,
		ST_HALVE_LAST,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t                   command;
		logic [CtxReqW-1:0]     context_req;
		logic signed [ResW-1:0] residual;
	} in_item_t;

	typedef struct packed {
		logic [TotalW-1:0] cum_freq;
		logic [FreqW-1:0]  sym_freq;
		logic [TotalW-1:0] total_freq;
		logic [MantW-1:0]  mantissa;
		logic [MbitsW-1:0] mantissa_bits;
		logic [CatW-1:0]   category;
	} out_item_t;

	typedef struct packed {
		logic            load;
		logic            scan_step;
		logic            scan_add;
		logic            update;
		logic            halve_add;
		logic            halve_last;
		logic            load_out;
		wsel_t           wsel;
		logic [CtxW-1:0] ctx;
		logic [SymW-1:0] sym_idx;
	} acm_ctl_t;

	typedef struct packed {
		logic t_zero;
		logic halve_req;
		logic out_free;
	} acm_sts_t;

endpackage

// ===== sv/acm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module acm_ram #(
	parameter int Width = 16,
	parameter int Depth = 264
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/acm_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: walks the frequency row of one context and drives the table memory.
module acm_seq import acm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	input  acm_sts_t         sts,
	output acm_ctl_t         ctl,
	output logic             mem_wr_en,
	output logic [AddrW-1:0] mem_wr_addr,
	output logic             mem_rd_en,
	output logic [AddrW-1:0] mem_rd_addr
);

	state_t                 state_q, state_d;
	logic [SymW-1:0]        s_q, s_d;
	logic [CtxW-1:0]        ctx_q;
	logic [NumContexts-1:0] row_vld_q;
	logic                   scan_pend_s1;
	logic                   halve_pend_s1;
	logic [AddrW-1:0]       addr_s1;
	logic [CtxW-1:0]        ctx_new;
	logic [AddrW-1:0]       row_base;
	logic [AddrW-1:0]       addr_cur;

	assign ctx_new  = CtxW'(in_item.context_req % NumContexts);
	assign row_base = AddrW'(ctx_q * NumSymbols);
	assign addr_cur = row_base + AddrW'(s_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			s_q           <= '0;
			ctx_q         <= '0;
			row_vld_q     <= '0;
			scan_pend_s1  <= 1'b0;
			halve_pend_s1 <= 1'b0;
			addr_s1       <= '0;
		end else begin
			state_q       <= state_d;
			s_q           <= s_d;
			scan_pend_s1  <= (state_q == ST_SCAN) && !sts.t_zero;
			halve_pend_s1 <= (state_q == ST_HALVE);
			addr_s1       <= addr_cur;
			if (ctl.load) begin
				ctx_q <= ctx_new;
				if (in_item.command == CMD_RESET) begin
					row_vld_q <= '0;
				end
			end
			if (state_q == ST_FILL && s_q == LastSym) begin
				row_vld_q[ctx_q] <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		s_d         = s_q;
		in_ready    = 1'b0;
		ctl         = '0;
		ctl.wsel    = WSEL_FILL;
		ctl.ctx     = ctx_q;
		ctl.sym_idx = s_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = addr_cur;
		mem_rd_en   = 1'b0;
		mem_rd_addr = addr_cur;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					s_d      = '0;
					if (in_item.command == CMD_RESET) begin
						state_d = ST_DONE;
					end else if (row_vld_q[ctx_new]) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FILL;
					end
				end
			end
			ST_FILL: begin
				mem_wr_en = 1'b1;
				ctl.wsel  = WSEL_FILL;
				if (s_q == LastSym) begin
					s_d     = '0;
					state_d = ST_SCAN;
				end else begin
					s_d = s_q + 1'b1;
				end
			end
			ST_SCAN: begin
				mem_rd_en    = 1'b1;
				ctl.scan_add = scan_pend_s1;
				if (sts.t_zero) begin
					state_d = ST_UPDATE;
				end else begin
					ctl.scan_step = 1'b1;
					s_d           = s_q + 1'b1;
				end
			end
			ST_UPDATE: begin
				ctl.update = 1'b1;
				ctl.wsel   = WSEL_UPDATE;
				mem_wr_en  = 1'b1;
				s_d        = '0;
				state_d    = sts.halve_req ? ST_HALVE : ST_DONE;
			end
			ST_HALVE: begin
				mem_rd_en     = 1'b1;
				ctl.wsel      = WSEL_HALVE;
				mem_wr_en     = halve_pend_s1;
				mem_wr_addr   = addr_s1;
				ctl.halve_add = halve_pend_s1;
				if (s_q == LastSym) begin
					state_d = ST_HALVE_LAST;
				end else begin
					s_d = s_q + 1'b1;
				end
			end
			ST_HALVE_LAST: begin
				ctl.wsel       = WSEL_HALVE;
				mem_wr_en      = 1'b1;
				mem_wr_addr    = addr_s1;
				ctl.halve_last = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/acm_dp.sv =====
`timescale 1ns / 1ps
// Datapath: zigzag shifter, shared accumulator, context totals and result registers.
module acm_dp import acm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  in_item_t            in_item,
	input  acm_ctl_t            ctl,
	output acm_sts_t            sts,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic [FreqW-1:0]    mem_rd_data,
	output logic [FreqW-1:0]    mem_wr_data,
	input  logic                out_ready,
	output logic                out_valid,
	output out_item_t           out_item
);

	logic [IncW-1:0]     inc_q;
	logic [CfgDataW-1:0] limit_q;
	logic [TotalW-1:0]   totals_q [NumContexts];
	logic [ResW-1:0]     zz;
	logic [ResW-1:0]     u_q;
	logic [ResW-1:0]     t_q;
	logic [ResW-1:0]     mask_q;
	logic [AccW-1:0]     acc_q;
	logic [AccW-1:0]     add_b;
	logic [AccW-1:0]     add_sum;
	logic [FreqW-1:0]    halved;
	logic [FreqSumW-1:0] sym_sum;
	logic [FreqW-1:0]    sym_sat;
	logic [TotalW-1:0]   tot_cur;
	logic [TotSumW-1:0]  tot_sum;
	logic [TotalW-1:0]   tot_new;
	logic [TotalW-1:0]   halve_total;
	out_item_t           res_q;
	out_item_t           out_q;
	logic                out_valid_q;

	assign zz = {in_item.residual[ResW-2:0], 1'b0} ^ {ResW{in_item.residual[ResW-1]}};

	assign halved  = FreqW'((FreqSumW'(mem_rd_data) + FreqSumW'(1)) >> 1);
	assign add_b   = ctl.scan_add ? AccW'(mem_rd_data) : AccW'(halved);
	assign add_sum = acc_q + add_b;

	assign sym_sum = FreqSumW'(mem_rd_data) + FreqSumW'(inc_q);
	assign sym_sat = sym_sum[FreqW] ? FreqMax : sym_sum[FreqW-1:0];

	assign tot_cur = totals_q[ctl.ctx];
	assign tot_sum = TotSumW'(tot_cur) + TotSumW'(inc_q);
	assign tot_new = tot_sum[TotalW] ? TotalMax : tot_sum[TotalW-1:0];

	assign halve_total = (add_sum > AccW'(TotalMax)) ? TotalMax : add_sum[TotalW-1:0];

	assign sts.t_zero    = (t_q == '0);
	assign sts.halve_req = (CfgDataW'(tot_new) >= limit_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		case (ctl.wsel)
			WSEL_FILL:   mem_wr_data = FreqInit;
			WSEL_UPDATE: mem_wr_data = sym_sat;
			WSEL_HALVE:  mem_wr_data = halved;
			default:     mem_wr_data = FreqInit;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q   <= IncReset;
			limit_q <= LimitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COUNT_INCREMENT: inc_q   <= cfg_data[IncW-1:0];
				REG_TOTAL_LIMIT:     limit_q <= cfg_data;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumContexts; i++) begin
				totals_q[i] <= TotalInit;
			end
		end else if (ctl.load && in_item.command == CMD_RESET) begin
			for (int i = 0; i < NumContexts; i++) begin
				totals_q[i] <= TotalInit;
			end
		end else if (ctl.update) begin
			totals_q[ctl.ctx] <= tot_new;
		end else if (ctl.halve_last) begin
			totals_q[ctl.ctx] <= halve_total;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			u_q    <= zz;
			t_q    <= zz;
			mask_q <= '0;
		end else if (ctl.scan_step) begin
			t_q    <= t_q >> 1;
			mask_q <= {mask_q[ResW-2:0], 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.update) begin
			acc_q <= '0;
		end else if (ctl.scan_add || ctl.halve_add) begin
			acc_q <= add_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && in_item.command == CMD_RESET) begin
			res_q <= '0;
		end else if (ctl.update) begin
			res_q.cum_freq      <= acc_q[TotalW-1:0];
			res_q.sym_freq      <= mem_rd_data;
			res_q.total_freq    <= tot_cur;
			res_q.mantissa      <= u_q[MantW-1:0] & mask_q[ResW-1:1];
			res_q.mantissa_bits <= (ctl.sym_idx == '0) ? '0 :
				MbitsW'(ctl.sym_idx - 1'b1);
			res_q.category      <= CatW'(ctl.sym_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== sv/adaptive_category_model_encoder.sv =====
`timescale 1ns / 1ps
// Top level of the adaptive category model encoder.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_ready    in_item  (in_item_t)
//   output   out        out_valid / out_ready  out_item (out_item_t)
//   config   in         cfg_we                 cfg_index, cfg_data
//
// A code command scans the frequency row of its context up to its category k, then
// updates it; the table memory port reads one frequency a cycle in the scan.
// The first code command on a context after reset or a reset command first fills
// that row of the table with ones.
// A rescale pass through the memory follows when the total reaches the limit.
// A reset command needs no clearing pass.
// The result waits in an output register, so a stalled output holds the next item
// only at its last step.
module adaptive_category_model_encoder import acm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_item,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	acm_ctl_t         ctl;
	acm_sts_t         sts;
	logic             mem_wr_en;
	logic [AddrW-1:0] mem_wr_addr;
	logic [FreqW-1:0] mem_wr_data;
	logic             mem_rd_en;
	logic [AddrW-1:0] mem_rd_addr;
	logic [FreqW-1:0] mem_rd_data;

	acm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.sts         (sts),
		.ctl         (ctl),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr)
	);

	acm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_item     (in_item),
		.ctl         (ctl),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mem_rd_data (mem_rd_data),
		.mem_wr_data (mem_wr_data),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_item    (out_item)
	);

	acm_ram #(
		.Width (FreqW),
		.Depth (NumEntries)
	) u_freq_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule

// ===== sv/acm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the adaptive category model encoder, bound to the top level.
module acm_checker import acm_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input in_item_t            in_item,
	input logic                out_valid,
	input logic                out_ready,
	input out_item_t           out_item,
	input logic                cfg_we,
	input logic [CfgIdxW-1:0]  cfg_index,
	input logic [CfgDataW-1:0] cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed or vanished while stalled");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again before the item was finished");

	a_mbits_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.category == '0 && out_item.mantissa_bits == '0) ||
			(out_item.category != '0 && out_item.category <= CatW'(ResW) &&
			CatW'(out_item.mantissa_bits) == out_item.category - 1'b1))
		else $error("mantissa bit count does not follow the category");

	a_mant_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.mantissa >> out_item.mantissa_bits) == '0)
		else $error("mantissa wider than its bit count");

	a_sym_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.sym_freq == '0 |->
			out_item.total_freq == '0 && out_item.category == '0)
		else $error("zero frequency on a coded residual");

endmodule

bind adaptive_category_model_encoder acm_checker u_acm_checker (.*);

// ===== test/tb_adaptive_category_model_encoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_category_model_encoder with its own model of the frequency tables.
module tb_adaptive_category_model_encoder;
	import acm_pkg::*;

	class category_model_checker;
		logic [FreqW-1:0]    freq [NumContexts][NumSymbols];
		logic [TotalW-1:0]   ctx_total [NumContexts];
		logic [IncW-1:0]     increment;
		logic [CfgDataW-1:0] limit;
		out_item_t           expected_results[$];
		int                  errors;

		function new();
			increment = IncReset;
			limit = LimitReset;
			errors = 0;
			clear_tables();
		endfunction

		function void clear_tables();
			foreach (freq[c, s]) freq[c][s] = FreqInit;
			foreach (ctx_total[c]) ctx_total[c] = TotalInit;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] data);
			if (idx == REG_COUNT_INCREMENT) begin
				increment = data[IncW-1:0];
			end else begin
				limit = data;
			end
		endfunction

		function void halve(int c);
			int unsigned sum;
			sum = 0;
			for (int s = 0; s < NumSymbols; s++) begin
				freq[c][s] = FreqW'((32'(freq[c][s]) + 32'd1) >> 1);
				sum += freq[c][s];
			end
			ctx_total[c] = (sum > TotalMax) ? TotalMax : TotalW'(sum);
		endfunction

		function void predict_transfer(in_item_t it);
			out_item_t   res;
			logic [31:0] r;
			logic [31:0] u;
			logic [31:0] mask;
			int unsigned cum;
			int unsigned f;
			int unsigned t;
			int          c;
			int          k;
			res = '0;
			if (it.command == CMD_RESET) begin
				clear_tables();
				expected_results.push_back(res);
				return;
			end
			c = it.context_req % NumContexts;
			r = it.residual;
			u = {r[30:0], 1'b0} ^ {32{r[31]}};
			k = 0;
			for (int b = 0; b < 32; b++) if (u[b]) k = b + 1;
			cum = 0;
			for (int s = 0; s < k; s++) cum += freq[c][s];
			res.cum_freq = TotalW'(cum);
			res.sym_freq = freq[c][k];
			res.total_freq = ctx_total[c];
			if (k > 1) begin
				mask = (32'd1 << (k - 1)) - 32'd1;
				res.mantissa = MantW'(u & mask);
				res.mantissa_bits = MbitsW'(k - 1);
			end
			res.category = CatW'(k);
			expected_results.push_back(res);
			f = freq[c][k] + increment;
			freq[c][k] = (f > FreqMax) ? FreqMax : FreqW'(f);
			t = ctx_total[c] + increment;
			ctx_total[c] = (t > TotalMax) ? TotalMax : TotalW'(t);
			if (ctx_total[c] >= limit) halve(c);
		endfunction

		function void compare(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= 10) begin
					$display("Mismatch in %s: expected %0d, got %0d", name, want, got);
				end
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("Result with no transfer waiting: category %0d", got.category);
				end
				return;
			end
			want = expected_results.pop_front();
			compare("cum_freq", want.cum_freq, got.cum_freq);
			compare("sym_freq", want.sym_freq, got.sym_freq);
			compare("total_freq", want.total_freq, got.total_freq);
			compare("mantissa", want.mantissa, got.mantissa);
			compare("mantissa_bits", want.mantissa_bits, got.mantissa_bits);
			compare("category", want.category, got.category);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_item_t            in_item;
	logic                out_valid;
	logic                out_ready;
	out_item_t           out_item;
	logic                cfg_we;
	cfg_reg_t            cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	category_model_checker predictor = new();
	bit send_steady;
	bit take_steady;

	adaptive_category_model_encoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic in_item_t make_item(cmd_t cmd, int ctx, logic [ResW-1:0] res);
		in_item_t it;
		it.command = cmd;
		it.context_req = CtxReqW'(ctx);
		it.residual = res;
		return it;
	endfunction

	function automatic logic [ResW-1:0] residual_for(int k);
		logic [31:0] u;
		if (k == 0) begin
			u = '0;
		end else begin
			u = (32'd1 << (k - 1)) | ($urandom & ((32'd1 << (k - 1)) - 32'd1));
		end
		return (u >> 1) ^ {32{u[0]}};
	endfunction

	function automatic in_item_t random_item(int favoured);
		in_item_t it;
		int       sel;
		it.command = ($urandom_range(0, 29) == 0) ? CMD_RESET : CMD_CODE;
		it.context_req = ($urandom_range(0, 1) == 0) ? CtxReqW'(favoured) : CtxReqW'($urandom);
		sel = $urandom_range(0, 7);
		if (sel == 0) begin
			it.residual = $urandom;
		end else if (sel < 4) begin
			it.residual = residual_for($urandom_range(0, 32));
		end else begin
			it.residual = residual_for($urandom_range(0, 6));
		end
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		int gap;
		if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		predictor.predict_transfer(it);
	endtask

	task automatic apply_settings(logic [IncW-1:0] inc, logic [CfgDataW-1:0] lim);
		logic [CfgDataW-1:0] inc_word;
		inc_word = {9'($urandom), inc};
		cfg_we <= 1'b1;
		cfg_index <= REG_COUNT_INCREMENT;
		cfg_data <= inc_word;
		@(posedge clk);
		cfg_index <= REG_TOTAL_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		predictor.write_reg(REG_COUNT_INCREMENT, inc_word);
		predictor.write_reg(REG_TOTAL_LIMIT, lim);
	endtask

	// Waits until every expected result has been checked, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (predictor.expected_results.size() != 0) @(posedge clk);
		repeat (48) @(posedge clk);
	endtask

	initial begin
		int stall;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 19) == 0) take_steady = !take_steady;
			stall = take_steady ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			predictor.check_result(out_item);
		end
	end

	initial begin
		in_item_t directed[$];
		int       phase_inc[7];
		int       phase_lim[7];
		int       favoured;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_COUNT_INCREMENT;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_item(CMD_CODE, 0, 32'h0000_0000));
		directed.push_back(make_item(CMD_CODE, 0, 32'hFFFF_FFFF));
		directed.push_back(make_item(CMD_CODE, 0, 32'h0000_0001));
		directed.push_back(make_item(CMD_CODE, 7, 32'h7FFF_FFFF));
		directed.push_back(make_item(CMD_CODE, 7, 32'h8000_0000));
		directed.push_back(make_item(CMD_CODE, 3, 32'hFFFF_FFFE));
		directed.push_back(make_item(CMD_CODE, 3, 32'h0000_0002));
		directed.push_back(make_item(CMD_CODE, 1, 32'h4000_0000));
		directed.push_back(make_item(CMD_CODE, 1, 32'hC000_0000));
		directed.push_back(make_item(CMD_CODE, 2, 32'd12345));
		directed.push_back(make_item(CMD_CODE, 2, -32'sd12345));
		directed.push_back(make_item(CMD_CODE, 4, 32'h5555_5555));
		directed.push_back(make_item(CMD_CODE, 4, 32'hAAAA_AAAA));
		directed.push_back(make_item(CMD_CODE, 7, 32'h0000_0000));
		directed.push_back(make_item(CMD_RESET, 5, 32'hFFFF_FFFF));
		directed.push_back(make_item(CMD_CODE, 7, 32'h0000_0000));
		directed.push_back(make_item(CMD_CODE, 7, 32'h7FFF_FFFF));
		directed.push_back(make_item(CMD_RESET, 0, 32'h0000_0000));
		directed.push_back(make_item(CMD_CODE, 6, 32'hFFFF_FFFF));
		directed.push_back(make_item(CMD_CODE, 6, 32'h0000_0003));
		foreach (directed[i]) send_item(directed[i]);
		drain();

		// One category repeated until its frequency saturates.
		apply_settings(8'd255, 17'd131071);
		for (int n = 0; n < 280; n++) begin
			if (n % 20 == 19) begin
				send_item(make_item(CMD_CODE, 5, residual_for($urandom_range(1, 4))));
			end else begin
				send_item(make_item(CMD_CODE, 5, 32'h0000_0000));
			end
		end
		drain();

		phase_inc = '{1, 255, 0, 200, 255, 7, 3};
		phase_lim = '{2, 600, 0, 131071, 65536, 300, 1};
		for (int p = 0; p < 7; p++) begin
			apply_settings(IncW'(phase_inc[p]), CfgDataW'(phase_lim[p]));
			favoured = $urandom_range(0, NumContexts - 1);
			repeat (30) send_item(random_item(favoured));
			drain();
		end

		if (predictor.errors == 0 && predictor.expected_results.size() == 0) begin
			$display("adaptive_category_model_encoder test passed");
		end else begin
			$display("adaptive_category_model_encoder test failed");
		end
		$finish;
	end

	initial begin
		#(600000 * 12);
		$display("adaptive_category_model_encoder test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/acm_pkg.sv
sv/acm_ram.sv
sv/acm_seq.sv
sv/acm_dp.sv
sv/adaptive_category_model_encoder.sv
sv/acm_checker.sv
test/tb_adaptive_category_model_encoder.sv
